### rtl/core/domain_warped_value_noise_macros.svh
// ============================================================================
// Domain-warped value noise: assertion macros
// Shared concurrent assertion forms, sampled on clk, quiet during reset.
// ============================================================================
`ifndef DOMAIN_WARPED_VALUE_NOISE_MACROS_SVH
`define DOMAIN_WARPED_VALUE_NOISE_MACROS_SVH

// Same-cycle implication.
`define DWVN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DWVN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dwvn_pkg.sv
// ============================================================================
// Domain-warped value noise package
// Widths, hash constants and pipeline depths shared by the block.
// ============================================================================
`default_nettype none

package dwvn_pkg;

    localparam int COORD_W    = 32;
    localparam int NOISE_W    = 16;
    localparam int FRAC_BITS  = 24;
    // Lattice values and blend weights span [0, 1.0] in Q.24.
    localparam int VAL_W      = 25;
    // Coordinate scaled to Q.24, plus one bit of headroom for offsets.
    localparam int BASE_W     = 41;
    // Register stages inside one value noise lane.
    localparam int VN_LAT     = 7;

    localparam int DEFAULT_OCTAVE_COUNT = 3;

    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

    // Warp offsets 5.2 and 1.3 in Q.24, rounded to nearest.
    localparam logic [BASE_W-1:0] OFFSET_X_Q24 = 41'd87241523;
    localparam logic [BASE_W-1:0] OFFSET_Y_Q24 = 41'd21810381;

endpackage

`default_nettype wire

### rtl/core/dwvn_coord_if.sv
// ============================================================================
// Coordinate channel
// Valid/ready channel that carries one sample position per beat.
// ============================================================================
`default_nettype none

interface dwvn_coord_if
    import dwvn_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;

    modport source (output valid, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

`default_nettype wire

### rtl/core/dwvn_noise_if.sv
// ============================================================================
// Noise result channel
// Valid/ready channel that carries one Q0.16 noise value per beat.
// ============================================================================
`default_nettype none

interface dwvn_noise_if
    import dwvn_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [NOISE_W-1:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

`default_nettype wire

### rtl/core/domain_warped_value_noise.sv
// Beat path: input, warp lanes, warp sums, warp position, final lanes, result.
// Throughput: one beat per cycle; every value noise lane is a 7-stage pipeline.
// The whole pipeline advances together and freezes only while the result
// register is full and the sink holds ready low.
// Reset clears all valid bits; data registers are not reset.
// ============================================================================
// Domain-warped value noise
// Two fbm fields form a warp; a third fbm at the warped position is the result.
// ============================================================================
`default_nettype none

module domain_warped_value_noise
    import dwvn_pkg::*;
#(
    parameter int OCTAVE_COUNT = DEFAULT_OCTAVE_COUNT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dwvn_coord_if.sink    coord_in,
    dwvn_noise_if.source  noise_out
);

    `include "domain_warped_value_noise_macros.svh"

    localparam int POS_W = BASE_W + 1 + OCTAVE_COUNT;
    localparam int LAT   = 2 * VN_LAT + 4;
    localparam int Q_IDX = VN_LAT + 1;

    logic                     pipe_en;
    logic [LAT-1:0]           vld_reg;

    logic [BASE_W-1:0]        x_reg, y_reg, xo_reg, yo_reg;
    logic [BASE_W-1:0]        dly_x_reg [VN_LAT+1];
    logic [BASE_W-1:0]        dly_y_reg [VN_LAT+1];
    logic [VAL_W-1:0]         qx_reg, qy_reg, qx_next, qy_next;
    logic [BASE_W-1:0]        px_reg, py_reg;
    logic [NOISE_W-1:0]       noise_reg;
    logic [VAL_W-1:0]         r_next;

    logic [VAL_W-1:0]         wx_val [OCTAVE_COUNT];
    logic [VAL_W-1:0]         wy_val [OCTAVE_COUNT];
    logic [VAL_W-1:0]         fn_val [OCTAVE_COUNT];
    logic [BASE_W-1:0]        x_next, y_next;

    // The pipeline moves whenever the result register is free or being drained.
    assign pipe_en        = !vld_reg[LAT-1] || noise_out.ready;
    assign coord_in.ready = pipe_en;
    assign noise_out.valid       = vld_reg[LAT-1];
    assign noise_out.noise_value = noise_reg;

    // Q16.16 to Q.24.
    assign x_next = {coord_in.coord_x[COORD_W-1], coord_in.coord_x, 8'h00};
    assign y_next = {coord_in.coord_y[COORD_W-1], coord_in.coord_y, 8'h00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], coord_in.valid};
        end
    end

    // Octave lanes: warp fields at the base and offset position, final field
    // at the warped position. Octave i samples at 2^i times the position.
    for (genvar i = 0; i < OCTAVE_COUNT; i++)
    begin : g_oct
        logic [POS_W-1:0] wxa, wya, wxb, wyb, fx, fy;
        assign wxa = {{(POS_W-BASE_W){x_reg[BASE_W-1]}},  x_reg}  << i;
        assign wya = {{(POS_W-BASE_W){y_reg[BASE_W-1]}},  y_reg}  << i;
        assign wxb = {{(POS_W-BASE_W){xo_reg[BASE_W-1]}}, xo_reg} << i;
        assign wyb = {{(POS_W-BASE_W){yo_reg[BASE_W-1]}}, yo_reg} << i;
        assign fx  = {{(POS_W-BASE_W){px_reg[BASE_W-1]}}, px_reg} << i;
        assign fy  = {{(POS_W-BASE_W){py_reg[BASE_W-1]}}, py_reg} << i;

        dwvn_vnoise #(.POS_W(POS_W)) u_warp_x (
            .clk(clk), .en(pipe_en), .pos_x(wxa), .pos_y(wya), .noise(wx_val[i])
        );
        dwvn_vnoise #(.POS_W(POS_W)) u_warp_y (
            .clk(clk), .en(pipe_en), .pos_x(wxb), .pos_y(wyb), .noise(wy_val[i])
        );
        dwvn_vnoise #(.POS_W(POS_W)) u_final (
            .clk(clk), .en(pipe_en), .pos_x(fx), .pos_y(fy), .noise(fn_val[i])
        );
    end

    // Octave sums, each octave weighted by a halving amplitude.
    always_comb
    begin
        qx_next = '0;
        qy_next = '0;
        r_next  = '0;
        for (int i = 0; i < OCTAVE_COUNT; i++)
        begin
            qx_next = qx_next + (wx_val[i] >> (i + 1));
            qy_next = qy_next + (wy_val[i] >> (i + 1));
            r_next  = r_next  + (fn_val[i] >> (i + 1));
        end
    end

    // Data path registers; all advance with the valid bits.
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            xo_reg <= x_next + OFFSET_X_Q24;
            yo_reg <= y_next + OFFSET_Y_Q24;

            dly_x_reg[0] <= x_reg;
            dly_y_reg[0] <= y_reg;
            for (int k = 1; k <= VN_LAT; k++)
            begin
                dly_x_reg[k] <= dly_x_reg[k-1];
                dly_y_reg[k] <= dly_y_reg[k-1];
            end

            qx_reg <= qx_next;
            qy_reg <= qy_next;

            // Displace by four times the warp.
            px_reg <= dly_x_reg[VN_LAT] + BASE_W'({qx_reg, 2'b00});
            py_reg <= dly_y_reg[VN_LAT] + BASE_W'({qy_reg, 2'b00});

            noise_reg <= r_next[FRAC_BITS-1 -: NOISE_W];
        end
    end

    // A stalled pipeline keeps every valid bit in place.
    `DWVN_ASSERT_NXT(a_stall_freezes, !pipe_en, $stable(vld_reg), "pipeline moved during stall")
    // An accepted beat occupies the first stage on the next cycle.
    `DWVN_ASSERT_NXT(a_accept_enters, coord_in.valid && pipe_en, vld_reg[0], "accepted beat lost")
    // The warp fbm stays below 1.0, so the displacement fits its headroom.
    `DWVN_ASSERT_IMP(a_warp_below_one, vld_reg[Q_IDX],
        qx_reg[VAL_W-1] == 1'b0 && qy_reg[VAL_W-1] == 1'b0, "warp reached 1.0")

endmodule

`default_nettype wire

### rtl/core/dwvn_vnoise.sv
// ============================================================================
// Value noise lane
// Seven-stage pipeline: lattice split, hash, smoothstep and bilinear blend.
// ============================================================================
`default_nettype none

module dwvn_vnoise
    import dwvn_pkg::*;
#(
    parameter int POS_W = 45
) (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [POS_W-1:0]        pos_x,
    input  wire logic [POS_W-1:0]        pos_y,
    output logic      [VAL_W-1:0]        noise
);

    // Blend a toward b by weight s, product truncated toward a.
    function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b,
                                               input logic [VAL_W-1:0] s);
        logic [VAL_W-1:0]   diff;
        logic [2*VAL_W-1:0] prod;
        logic [VAL_W-1:0]   step;
        diff = (b >= a) ? (b - a) : (a - b);
        prod = diff * s;
        step = prod[FRAC_BITS +: VAL_W];
        return (b >= a) ? (a + step) : (a - step);
    endfunction

    // Stage 1: lattice cell and fraction.
    logic [31:0]          cx_reg, cy_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;

    // Stage 2: axis hash products and first smoothstep product.
    logic [31:0]          mx0_reg, mx1_reg, my0_reg, my1_reg;
    logic [FRAC_BITS-1:0] t2x_reg, t2y_reg;
    logic [FRAC_BITS+1:0] kx_reg, ky_reg;

    // Stages 3 to 5: corner hashes, then lattice values.
    logic [31:0]          h1_reg [4];
    logic [31:0]          h2_reg [4];
    logic [VAL_W-1:0]     val_reg [4];
    logic [VAL_W-1:0]     sx3_reg, sy3_reg, sx4_reg, sy4_reg, sx5_reg, sy5_reg;

    // Stage 6: row blends. Stage 7: column blend.
    logic [VAL_W-1:0]     r0_reg, r1_reg, sy6_reg, noise_reg;

    logic [31:0]          h1_next [4];
    logic [31:0]          h2_next [4];
    logic [VAL_W-1:0]     val_next [4];
    logic [2*FRAC_BITS-1:0] tx_sq, ty_sq;
    logic [2*FRAC_BITS+1:0] ex_prod, ey_prod;

    assign tx_sq   = fx_reg * fx_reg;
    assign ty_sq   = fy_reg * fy_reg;
    assign ex_prod = t2x_reg * kx_reg;
    assign ey_prod = t2y_reg * ky_reg;

    // Corner hash mixing; corner bit 0 selects x+1, bit 1 selects y+1.
    always_comb
    begin
        logic [31:0] hs;
        logic [31:0] hm;
        for (int c = 0; c < 4; c++)
        begin
            hs = (c[0] ? mx1_reg : mx0_reg) + (c[1] ? my1_reg : my0_reg);
            h1_next[c] = hs ^ (hs >> 13);
            h2_next[c] = h1_reg[c] * HASH_MUL_MIX;
            hm = h2_reg[c] ^ (h2_reg[c] >> 16);
            // m * 2^24 / (2^24 - 1), rounded, is m plus one from the midpoint up.
            val_next[c] = VAL_W'(hm[FRAC_BITS-1:0]) + VAL_W'(hm[FRAC_BITS-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg  <= {{(56-POS_W){pos_x[POS_W-1]}}, pos_x[POS_W-1:FRAC_BITS]};
            cy_reg  <= {{(56-POS_W){pos_y[POS_W-1]}}, pos_y[POS_W-1:FRAC_BITS]};
            fx_reg  <= pos_x[FRAC_BITS-1:0];
            fy_reg  <= pos_y[FRAC_BITS-1:0];

            mx0_reg <= cx_reg * HASH_MUL_X;
            mx1_reg <= (cx_reg + 32'd1) * HASH_MUL_X;
            my0_reg <= cy_reg * HASH_MUL_Y;
            my1_reg <= (cy_reg + 32'd1) * HASH_MUL_Y;
            t2x_reg <= tx_sq[FRAC_BITS +: FRAC_BITS];
            t2y_reg <= ty_sq[FRAC_BITS +: FRAC_BITS];
            kx_reg  <= (FRAC_BITS+2)'(3 << FRAC_BITS) - {1'b0, fx_reg, 1'b0};
            ky_reg  <= (FRAC_BITS+2)'(3 << FRAC_BITS) - {1'b0, fy_reg, 1'b0};

            sx3_reg <= ex_prod[FRAC_BITS +: VAL_W];
            sy3_reg <= ey_prod[FRAC_BITS +: VAL_W];
            sx4_reg <= sx3_reg;
            sy4_reg <= sy3_reg;
            sx5_reg <= sx4_reg;
            sy5_reg <= sy4_reg;
            for (int c = 0; c < 4; c++)
            begin
                h1_reg[c]  <= h1_next[c];
                h2_reg[c]  <= h2_next[c];
                val_reg[c] <= val_next[c];
            end

            r0_reg    <= blend(val_reg[0], val_reg[1], sx5_reg);
            r1_reg    <= blend(val_reg[2], val_reg[3], sx5_reg);
            sy6_reg   <= sy5_reg;

            noise_reg <= blend(r0_reg, r1_reg, sy6_reg);
        end
    end

    assign noise = noise_reg;

endmodule

`default_nettype wire
